FILE: hw/rtl/mandelbrot_escape_time_assert.svh
// ----------------------------------------------------------------------------
// mandelbrot escape time assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// same-cycle implication
`define MBE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// types, register codes and format constants of the escape time block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  localparam int Z_W            = 32;
  localparam int PROD_W         = 2 * Z_W;
  localparam int FRAC_BITS      = 28;
  localparam int CNT_OUT_W      = 13;
  localparam int RAD_W          = 36;
  localparam int CFG_IDX_W      = 2;
  localparam int ITER_BOUND_DEF = 5000;

  localparam logic [CNT_OUT_W-1:0] MAX_ITER_RST = CNT_OUT_W'(5000);
  localparam logic [RAD_W-1:0]     RADIUS_RST   = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [Z_W-1:0] c_re;
    logic signed [Z_W-1:0] c_im;
  } in_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] escape_count;
    logic                 in_set;
  } out_t;

  typedef enum logic [1:0] {
    OP_RE_RE = 2'd0,
    OP_IM_IM = 2'd1,
    OP_RE_IM = 2'd2
  } op_sel_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQ_RE  = 5'b00010,
    S_SQ_IM  = 5'b00100,
    S_CROSS  = 5'b01000,
    S_UPDATE = 5'b10000
  } state_t;

  typedef struct packed {
    logic    load;
    op_sel_t op_sel;
    logic    cap_rr;
    logic    cap_diff;
    logic    update;
  } ctrl_t;

  typedef struct packed {
    logic esc;
    logic ovf;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mbe_mul.sv
// ----------------------------------------------------------------------------
// mbe_mul
// shared signed 32x32 multiplier with operand select and registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbe_mul
  import mbe_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [Z_W-1:0]    zre,
  input  wire logic signed [Z_W-1:0]    zim,
  input  wire op_sel_t                  op_sel,
  output logic signed [PROD_W-1:0]      prod_r
);

  logic signed [Z_W-1:0] opa;
  logic signed [Z_W-1:0] opb;

  always_comb begin
    case (op_sel)
      OP_RE_RE: begin
        opa = zre;
        opb = zre;
      end
      OP_IM_IM: begin
        opa = zim;
        opb = zim;
      end
      OP_RE_IM: begin
        opa = zre;
        opb = zim;
      end
      default: begin
        opa = zre;
        opb = zim;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mbe_dp.sv
// ----------------------------------------------------------------------------
// mbe_dp
// z registers, square/difference holding, modulus and format overflow checks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbe_dp
  import mbe_pkg::*;
(
  input  wire logic             clk,
  input  wire in_t              in_data,
  input  wire ctrl_t            ctl,
  input  wire logic [RAD_W-1:0] radius_sq,
  output status_t               st
);

  logic signed [Z_W-1:0]    cre_r;
  logic signed [Z_W-1:0]    cim_r;
  logic signed [Z_W-1:0]    zre_r;
  logic signed [Z_W-1:0]    zim_r;
  logic signed [PROD_W-1:0] rr_r;
  logic signed [PROD_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        mod_sum;
  logic [PROD_W-1:0]        mod_sq;
  logic signed [PROD_W-1:0] nre;
  logic signed [PROD_W-1:0] nim;
  logic                     nre_ok;
  logic                     nim_ok;

  mbe_mul u_mul (
    .clk    (clk),
    .zre    (zre_r),
    .zim    (zim_r),
    .op_sel (ctl.op_sel),
    .prod_r (prod_r)
  );

  // squares are non-negative, so the unsigned sum cannot wrap
  assign mod_sum = PROD_W'(unsigned'(rr_r)) + PROD_W'(unsigned'(prod_r));
  assign mod_sq  = mod_sum >> FRAC_BITS;
  assign st.esc  = mod_sq > {{(PROD_W-RAD_W){1'b0}}, radius_sq};

  assign nre    = (diff_r >>> FRAC_BITS) + PROD_W'(cre_r);
  assign nim    = (prod_r >>> (FRAC_BITS - 1)) + PROD_W'(cim_r);
  assign nre_ok = (&nre[PROD_W-1:Z_W-1]) | ~(|nre[PROD_W-1:Z_W-1]);
  assign nim_ok = (&nim[PROD_W-1:Z_W-1]) | ~(|nim[PROD_W-1:Z_W-1]);
  assign st.ovf = ~(nre_ok & nim_ok);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cre_r <= in_data.c_re;
      cim_r <= in_data.c_im;
      zre_r <= in_data.c_re;
      zim_r <= in_data.c_im;
    end else if (ctl.update) begin
      zre_r <= signed'(nre[Z_W-1:0]);
      zim_r <= signed'(nim[Z_W-1:0]);
    end
    if (ctl.cap_rr) begin
      rr_r <= prod_r;
    end
    if (ctl.cap_diff) begin
      diff_r <= rr_r - prod_r;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// mbe_ctrl
// iteration sequencer: multiplier schedule, iteration count, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbe_ctrl
  import mbe_pkg::*;
#(
  parameter int ITER_BOUND = ITER_BOUND_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [CNT_OUT_W-1:0] max_iter,
  input  wire status_t              st,
  output ctrl_t                     ctl,
  output logic                      busy,
  output logic                      out_valid,
  output out_t                      out_data
);

  localparam int BND_W = $clog2(ITER_BOUND + 1);
  localparam int LIM_W = (BND_W > CNT_OUT_W) ? BND_W : CNT_OUT_W;
  localparam logic [LIM_W-1:0] BOUND = LIM_W'(ITER_BOUND);

  state_t           state_r, state_nxt;
  logic [LIM_W-1:0] cnt_r, cnt_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;
  logic [LIM_W-1:0] cnt_inc;
  logic [LIM_W-1:0] max_iter_ext;

  assign cnt_inc      = cnt_r + LIM_W'(1);
  assign max_iter_ext = LIM_W'(max_iter);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    ctl.op_sel    = OP_RE_RE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          lim_nxt   = (max_iter_ext > BOUND) ? BOUND : max_iter_ext;
          state_nxt = S_SQ_RE;
        end
      end
      S_SQ_RE: begin
        ctl.op_sel = OP_RE_RE;
        state_nxt  = S_SQ_IM;
      end
      S_SQ_IM: begin
        ctl.op_sel = OP_IM_IM;
        ctl.cap_rr = 1'b1;
        state_nxt  = S_CROSS;
      end
      S_CROSS: begin
        ctl.op_sel   = OP_RE_IM;
        ctl.cap_diff = 1'b1;
        if ((cnt_r != '0) && st.esc) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.escape_count = cnt_r[CNT_OUT_W-1:0];
          out_data_nxt.in_set       = 1'b0;
          state_nxt                 = S_IDLE;
        end else if (cnt_inc >= lim_r) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.escape_count = '0;
          out_data_nxt.in_set       = 1'b1;
          state_nxt                 = S_IDLE;
        end else begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        ctl.update = 1'b1;
        cnt_nxt    = cnt_inc;
        if (st.ovf) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.escape_count = cnt_inc[CNT_OUT_W-1:0];
          out_data_nxt.in_set       = 1'b0;
          state_nxt                 = S_IDLE;
        end else begin
          state_nxt = S_SQ_RE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    lim_r      <= lim_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape-time test of one complex point c, signed Q3.28, z = z*z + c
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result strobe. One shared 32x32 multiplier forms re^2, im^2 and
// re*im in turn; each iteration steps through S_SQ_RE, S_SQ_IM, S_CROSS and
// S_UPDATE. A request ends when the point escapes, when an iteration leaves
// the number format, or when the iteration limit is reached. The result is on
// out_data for exactly one cycle with out_valid high and cannot be held off,
// so the receiver must take it then. A new request may be accepted in that
// same cycle. Configuration is written over cfg_* (always ready) and should
// only change while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int ITER_BOUND = ITER_BOUND_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RAD_W-1:0]     cfg_data
);

  logic [CNT_OUT_W-1:0] max_iter_r;
  logic [RAD_W-1:0]     radius_r;
  ctrl_t                ctl;
  status_t              st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      radius_r   <= RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_ITER: max_iter_r <= cfg_data[CNT_OUT_W-1:0];
        CFG_RADIUS:   radius_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mbe_ctrl #(
    .ITER_BOUND (ITER_BOUND)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .max_iter  (max_iter_r),
    .st        (st),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  mbe_dp u_dp (
    .clk       (clk),
    .in_data   (in_data),
    .ctl       (ctl),
    .radius_sq (radius_r),
    .st        (st)
  );

  `MBE_ASSERT_SAME(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `MBE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request did not start")
  `MBE_ASSERT_SAME(a_in_set_zero, out_valid && out_data.in_set,
                   out_data.escape_count == '0, "in_set with nonzero count")
  `MBE_ASSERT_SAME(a_load_idle, ctl.load, !busy && start, "load outside request")

endmodule

`default_nettype wire

FILE: tb/mandelbrot_escape_time_checker.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_checker
// watches the request, result and register channels of the escape time block,
// computes the escape count of every accepted point from its own copy of the
// registers and compares each result strobe with the oldest outstanding one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_checker
  import mbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  out_t                 out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_data,
  output int                   failures,
  output int                   pending
);

  localparam longint Z_LO = -(longint'(1) << (Z_W - 1));
  localparam longint Z_HI = (longint'(1) << (Z_W - 1)) - 1;

  out_t                 escape_q[$];
  logic [CNT_OUT_W-1:0] iter_limit;
  logic [RAD_W-1:0]     radius_sq;

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic out_t escape_time(in_t p, logic [CNT_OUT_W-1:0] lim_raw,
                                       logic [RAD_W-1:0] rad);
    longint          cr;
    longint          ci;
    longint          zr;
    longint          zi;
    longint          rr;
    longint          ii;
    longint          ri;
    longint          nr;
    longint          ni;
    longint unsigned msq;
    int              lim;
    int              count;
    out_t            r;
    cr = $signed(p.c_re);
    ci = $signed(p.c_im);
    zr = cr;
    zi = ci;
    lim = int'(lim_raw);
    if (lim > ITER_BOUND_DEF) lim = ITER_BOUND_DEF;
    count = 0;
    for (int n = 1; n < lim; n++) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      nr = ((rr - ii) >>> FRAC_BITS) + cr;
      ni = (ri >>> (FRAC_BITS - 1)) + ci;
      // leaving the 32-bit format counts as an escape
      if (nr < Z_LO || nr > Z_HI || ni < Z_LO || ni > Z_HI) begin
        count = n;
        break;
      end
      msq = (unsigned'(nr * nr) + unsigned'(ni * ni)) >> FRAC_BITS;
      if (msq > rad) begin
        count = n;
        break;
      end
      zr = nr;
      zi = ni;
    end
    r.escape_count = CNT_OUT_W'(count);
    r.in_set       = (count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    int   errs;
    out_t want;
    errs = 0;
    if (!rst_n) begin
      iter_limit <= MAX_ITER_RST;
      radius_sq  <= RADIUS_RST;
      escape_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_ITER: iter_limit <= cfg_data[CNT_OUT_W-1:0];
          CFG_RADIUS:   radius_sq  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (escape_q.size() == 0) begin
          $error("result with no request outstanding: escape_count %0d in_set %0d",
                 out_data.escape_count, out_data.in_set);
          errs++;
        end else begin
          want = escape_q.pop_front();
          if (out_data.escape_count !== want.escape_count) begin
            $error("escape_count mismatch: expected %0d, actual %0d",
                   want.escape_count, out_data.escape_count);
            errs++;
          end
          if (out_data.in_set !== want.in_set) begin
            $error("in_set mismatch: expected %0d, actual %0d",
                   want.in_set, out_data.in_set);
            errs++;
          end
        end
      end
      if (start && !busy) escape_q.push_back(escape_time(in_data, iter_limit, radius_sq));
    end
    failures <= failures + errs;
    pending  <= escape_q.size();
  end

endmodule

FILE: tb/mandelbrot_escape_time_test.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_test
// drives points and register settings into the escape time block: a directed
// set of corner points and limits, then randomized phases of points under
// random limits and radii, with random request gaps; a separate checker
// predicts and compares every result and the verdict is taken from its count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_test;
  import mbe_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int TAIL_CYCLES    = 100;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_POINTS   = 12;
  localparam int QUIET_PHASES   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  localparam logic signed [Z_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [Z_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Z_W-1:0] Q_ONE = 32'sh1000_0000;
  localparam logic [RAD_W-1:0]      RADIUS_TWO_SQ = RAD_W'(4) << FRAC_BITS;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  in_data = '0;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RAD_W-1:0]     cfg_data = '0;
  int                   failures;
  int                   pending;
  int                   quiet_cycles = 0;
  bit                   gaps_on = 1'b1;

  mandelbrot_escape_time dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mandelbrot_escape_time_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic in_t pt(logic signed [Z_W-1:0] re, logic signed [Z_W-1:0] im);
    in_t p;
    p.c_re = re;
    p.c_im = im;
    return p;
  endfunction

  function automatic logic signed [Z_W-1:0] corner_value();
    logic signed [Z_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = Q_MIN;
      1:       v = Q_MAX;
      2:       v = '0;
      3:       v = -1;
      4:       v = Q_ONE;
      default: v = -Q_ONE;
    endcase
    return v;
  endfunction

  function automatic in_t rand_point();
    in_t p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        // box around the set, re in [-2.5, 1.5], im in [-1.5, 1.5]
        p.c_re = $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2800_0000;
        p.c_im = $signed($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000;
      end
      6, 7: begin
        p.c_re = $urandom;
        p.c_im = $urandom;
      end
      8: begin
        // close to the origin
        p.c_re = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        p.c_im = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      end
      default: begin
        p.c_re = corner_value();
        p.c_im = corner_value();
      end
    endcase
    return p;
  endfunction

  task automatic send_point(input in_t p);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [CNT_OUT_W-1:0] limit, input logic [RAD_W-1:0] radius);
    logic [63:0] noise;
    drain();
    noise = {$urandom, $urandom};
    // unused upper bits of the limit word carry noise
    write_reg(CFG_MAX_ITER, {noise[RAD_W-1:CNT_OUT_W], limit});
    if ($urandom_range(0, 1) == 1) begin
      noise = {$urandom, $urandom};
      write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO, noise[RAD_W-1:0]);
    end
    write_reg(CFG_RADIUS, radius);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CNT_OUT_W-1:0] rand_limit();
    logic [CNT_OUT_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = CNT_OUT_W'($urandom_range(0, 2));
      1:       v = CNT_OUT_W'($urandom_range(200, 400));
      default: v = CNT_OUT_W'($urandom_range(3, 64));
    endcase
    return v;
  endfunction

  function automatic logic [RAD_W-1:0] rand_radius();
    logic [63:0]     w;
    logic [RAD_W-1:0] v;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1:    v = RADIUS_TWO_SQ;
      2:       v = w[RAD_W-1:0];
      3:       v = '0;
      4:       v = RADIUS_RST;
      default: v = RAD_W'($urandom_range(0, 16)) << FRAC_BITS;
    endcase
    return v;
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: full limit, saturated radius
    send_point(pt('0, '0));
    send_point(pt(Q_MIN, Q_MIN));
    send_point(pt(Q_MAX, Q_MAX));
    send_point(pt(Q_MAX, Q_MIN));
    send_point(pt(Q_MIN, '0));
    send_point(pt(-(Q_ONE <<< 1), '0));

    // limits that run no iteration
    configure(CNT_OUT_W'(0), RADIUS_RST);
    send_point(pt(Q_ONE, Q_ONE));
    send_point(pt(Q_MIN, Q_MIN));
    configure(CNT_OUT_W'(1), RADIUS_TWO_SQ);
    send_point(pt(Q_MAX, Q_MAX));

    // single iteration
    configure(CNT_OUT_W'(2), RADIUS_TWO_SQ);
    send_point(pt(Q_ONE, Q_ONE));
    send_point(pt('0, '0));
    send_point(pt(-Q_ONE, '0));

    // limit above the bound saturates
    configure('1, RADIUS_TWO_SQ);
    send_point(pt(Q_ONE >>> 1, '0));
    send_point(pt((Q_ONE >>> 2) + 32'sh0050_0000, '0));
    send_point(pt(-(Q_ONE >>> 2) * 3, Q_ONE / 10));
    send_point(pt('0, '0));

    // zero radius, threshold of the modulus
    configure(CNT_OUT_W'(40), '0);
    send_point(pt('0, '0));
    send_point(pt(32'sd1, '0));
    send_point(pt(32'sh0000_4000, '0));
    send_point(pt(32'sh0000_3fff, '0));

    configure(CNT_OUT_W'(5001), RADIUS_RST);
    send_point(pt(Q_MIN, Q_MAX));
    send_point(pt(Q_ONE, -Q_ONE));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph >= RAND_PHASES - QUIET_PHASES) gaps_on = 1'b0;
      configure(rand_limit(), rand_radius());
      for (int k = 0; k < PHASE_POINTS; k++) send_point(rand_point());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
